/* sv/stmp_pkg.sv */
`default_nettype none
package stmp_pkg;
  localparam int unsigned LEAF_COUNT = 1024;
  localparam int unsigned LEVELS = $clog2(LEAF_COUNT);
  localparam int unsigned SPAN = 2 ** LEVELS;
  localparam int unsigned NODE_AW = LEVELS + 1;
  localparam int unsigned NODE_DEPTH = 2 ** NODE_AW;
  localparam int unsigned EW = 30;
  localparam logic [EW-1:0] MODULUS = 30'd1000000007;
  // floor(2^(2*EW) / MODULUS), used to estimate the quotient.
  localparam logic [EW:0] BARRETT_MU = 31'd1152921496;
  localparam int unsigned POS_W = 10;
  localparam int unsigned SYM_W = 8;

  localparam logic [SYM_W-1:0] CH_A = 8'h41;
  localparam logic [SYM_W-1:0] CH_E = 8'h45;
  localparam logic [SYM_W-1:0] CH_I = 8'h49;
  localparam logic [SYM_W-1:0] CH_O = 8'h4F;
  localparam logic [SYM_W-1:0] CH_U = 8'h55;
  localparam logic [SYM_W-1:0] CH_S = 8'h53;
  localparam logic [SYM_W-1:0] CH_D = 8'h44;
  localparam logic [SYM_W-1:0] CH_H = 8'h48;
  localparam logic [SYM_W-1:0] CH_QUERY = 8'h3F;

  typedef struct packed {
    logic [EW-1:0] a;
    logic [EW-1:0] b;
    logic [EW-1:0] c;
    logic [EW-1:0] d;
  } mat_t;

  localparam mat_t IDENTITY = '{a: 30'd1, b: 30'd0, c: 30'd0, d: 30'd1};

  function automatic mat_t symbol_matrix(input logic [SYM_W-1:0] ch);
    mat_t m;
    m = IDENTITY;
    unique case (ch)
      CH_A, CH_E, CH_I, CH_O, CH_U: m = '{a: 30'd0, b: 30'd1, c: 30'd1, d: 30'd0};
      CH_S, CH_D: m = '{a: 30'd0, b: 30'd1, c: 30'd0, d: 30'd1};
      CH_H: m = '{a: 30'd1, b: 30'd0, c: 30'd1, d: 30'd0};
      CH_QUERY: m = '{a: 30'd19, b: 30'd7, c: 30'd6, d: 30'd20};
      default: m = IDENTITY;
    endcase
    return m;
  endfunction
endpackage
`default_nettype wire

/* sv/stmp_mulmod.sv */
`default_nettype none
// Modular multiply with Barrett reduction: full product, quotient estimate,
// remainder, final correction, each a registered step; done rises with the result.
module stmp_mulmod (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [stmp_pkg::EW-1:0] x,
  input  wire logic [stmp_pkg::EW-1:0] y,
  output logic                         done,
  output logic [stmp_pkg::EW-1:0]      prod
);
  import stmp_pkg::*;

  logic [2*EW-1:0] full;
  logic [2*EW+1:0] qmu;
  logic [EW+1:0]   rem;
  logic [EW+1:0]   qp;
  logic [EW+1:0]   red;
  logic            v1;
  logic            v2;
  logic            v3;

  // The estimated quotient is at most two short, so the remainder is below
  // three times the modulus and fits in EW+2 bits.
  always_comb begin
    qp  = (EW+2)'(qmu[2*EW+1:EW+1]) * (EW+2)'(MODULUS);
    red = (rem >= ((EW+2)'(MODULUS) << 1)) ? rem - ((EW+2)'(MODULUS) << 1) :
          (rem >= (EW+2)'(MODULUS)) ? rem - (EW+2)'(MODULUS) : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (start) full <= (2*EW)'(x) * (2*EW)'(y);
    if (v1)    qmu  <= (2*EW+2)'(full[2*EW-1:EW-1]) * (2*EW+2)'(BARRETT_MU);
    if (v2)    rem  <= full[EW+1:0] - qp;
    if (v3)    prod <= red[EW-1:0];
  end
endmodule
`default_nettype wire

/* sv/stmp_core.sv */
`default_nettype none
// Node memory and the leaf-to-root walk. The eight modular products of a
// level run in parallel on eight pipelined multipliers. After reset a
// clearing pass writes the identity into every node.
module stmp_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [stmp_pkg::POS_W-1:0] pos,
  input  wire logic [stmp_pkg::SYM_W-1:0] sym,
  output logic                            done,
  output logic [stmp_pkg::EW-1:0]         root_a,
  output logic                            busy
);
  import stmp_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_WAIT  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_SUM   = 7'b0100000,
    S_ROOT  = 7'b1000000
  } state_t;

  state_t state;
  mat_t mem [NODE_DEPTH];
  logic [NODE_AW-1:0] clr_addr;
  logic [NODE_AW-1:0] node;
  mat_t cur;
  mat_t rd;
  logic [NODE_AW-1:0] rd_addr;
  logic mem_we;
  logic [NODE_AW-1:0] mem_waddr;
  mat_t mem_wdata;
  logic [NODE_AW-1:0] leaf_addr;
  mat_t leaf_mat;
  logic in_range;
  mat_t sum;
  mat_t lm;
  mat_t rm;
  logic [7:0] mdone;
  logic [EW-1:0] px [8];
  logic [EW-1:0] py [8];
  logic [EW-1:0] pp [8];
  logic mstart;

  function automatic logic [EW-1:0] addmod(input logic [EW-1:0] p, input logic [EW-1:0] q);
    logic [EW:0] s;
    s = {1'b0, p} + {1'b0, q};
    return (s >= {1'b0, MODULUS}) ? EW'(s - {1'b0, MODULUS}) : s[EW-1:0];
  endfunction

  // One write port and one read port; the read data is registered into rd.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd <= mem[rd_addr];
  end

  assign leaf_addr = NODE_AW'(SPAN) + NODE_AW'(pos);
  assign leaf_mat  = symbol_matrix(sym);
  assign in_range  = 32'(pos) < LEAF_COUNT;

  always_comb begin
    rd_addr = (state == S_ROOT || node == NODE_AW'(1)) ? NODE_AW'(1) : (node ^ NODE_AW'(1));
    if (node[0]) begin
      lm = rd;
      rm = cur;
    end else begin
      lm = cur;
      rm = rd;
    end
    px[0] = lm.a; py[0] = rm.a; px[1] = lm.b; py[1] = rm.c;
    px[2] = lm.a; py[2] = rm.b; px[3] = lm.b; py[3] = rm.d;
    px[4] = lm.c; py[4] = rm.a; px[5] = lm.d; py[5] = rm.c;
    px[6] = lm.c; py[6] = rm.b; px[7] = lm.d; py[7] = rm.d;
    sum.a = addmod(pp[0], pp[1]);
    sum.b = addmod(pp[2], pp[3]);
    sum.c = addmod(pp[4], pp[5]);
    sum.d = addmod(pp[6], pp[7]);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = IDENTITY;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_IDLE && start && in_range) begin
      mem_we    = 1'b1;
      mem_waddr = leaf_addr;
      mem_wdata = leaf_mat;
    end else if (state == S_SUM) begin
      mem_we    = 1'b1;
      mem_waddr = node >> 1;
      mem_wdata = sum;
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_mul
    stmp_mulmod u_mul (
      .clk, .rst, .start(mstart), .x(px[g]), .y(py[g]), .done(mdone[g]), .prod(pp[g])
    );
  end

  assign mstart = (state == S_WAIT);
  assign busy   = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + NODE_AW'(1);
          if (clr_addr == NODE_AW'(NODE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (in_range) begin
              node  <= leaf_addr;
              cur   <= leaf_mat;
              state <= S_READ;
            end else begin
              state <= S_ROOT;
            end
          end
        end
        S_READ: state <= S_WAIT;
        S_WAIT: state <= S_MUL;
        S_MUL:  if (&mdone) state <= S_SUM;
        S_SUM: begin
          cur  <= sum;
          node <= node >> 1;
          if ((node >> 1) == NODE_AW'(1)) begin
            state <= S_ROOT;
          end else begin
            state <= S_READ;
          end
        end
        S_ROOT: begin
          // The root read issued here lands in rd in the next cycle, together with done.
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // On the cycle done is high, rd holds the root as read in S_ROOT.
  assign root_a = rd.a;
endmodule
`default_nettype wire

/* sv/segment_tree_matrix_product.sv */
// Segment tree of 2x2 matrix products modulo 1000000007.
// Input channel: position, symbol with valid/stall; each beat overwrites one
// leaf with the matrix chosen by the symbol and recomputes the path to the root.
// Output channel: count with valid/stall, one beat per input beat, holding
// the top-left entry of the root product.
// A position at or past the leaf count writes nothing and only reports.
// Each tree level steps through sibling read, read wait, pipelined modular
// multiply (eight in parallel) and a sum with write-back. After the ten
// levels the root is read, and the result passes through the output register
// before the beat is offered.
// One item is processed at a time; input stall is high while busy or while
// a result is pending.
// After reset a clearing pass sets every node to the identity; input stall
// stays high throughout.
// When the receiver stalls, count is held and no new item is taken.
`default_nettype none
module segment_tree_matrix_product (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [stmp_pkg::POS_W-1:0] position,
  input  wire logic [stmp_pkg::SYM_W-1:0] symbol,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [stmp_pkg::EW-1:0]         count
);
  import stmp_pkg::*;

  logic busy;
  logic done;
  logic [EW-1:0] root_a;
  logic take;

  assign in_stall = busy | out_valid | done;
  assign take     = in_valid & ~in_stall;

  stmp_core u_core (
    .clk, .rst, .start(take), .pos(position), .sym(symbol),
    .done, .root_a, .busy
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (done) begin
        out_valid <= 1'b1;
        count     <= root_a;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* tb/tb_segment_tree_matrix_product.sv */
`default_nettype none
module tb_segment_tree_matrix_product;
  import stmp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_DIRECTED = 14;
  localparam int N_RANDOM   = 1450;
  localparam int N_ITEMS    = N_DIRECTED + N_RANDOM;
  localparam int DRAIN_CYCLES = 2 * 34 * (LEVELS + 2);
  localparam logic [SYM_W-1:0] CH_PLAIN = 8'h78;
  localparam longint unsigned PRIME = 64'd1000000007;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [POS_W-1:0] position;
  logic [SYM_W-1:0] symbol;
  logic [EW-1:0] count;

  segment_tree_matrix_product u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .position(position), .symbol(symbol), .out_valid(out_valid),
    .out_stall(out_stall), .count(count)
  );

  typedef struct {
    logic [POS_W-1:0] pos;
    logic [SYM_W-1:0] sym;
    bit               typed;
    logic [EW-1:0]    value;
  } stim_t;

  stim_t stim [N_ITEMS];
  mat_t tree [1:2*LEAF_COUNT-1];
  logic [EW-1:0] exp_counts [N_ITEMS];
  int fed, checked, mismatches;
  bit in_fire;

  function automatic mat_t leaf_matrix(logic [SYM_W-1:0] ch);
    mat_t m;
    m = IDENTITY;
    case (ch)
      CH_A, CH_E, CH_I, CH_O, CH_U: m = '{a: 30'd0, b: 30'd1, c: 30'd1, d: 30'd0};
      CH_S, CH_D: m = '{a: 30'd0, b: 30'd1, c: 30'd0, d: 30'd1};
      CH_H: m = '{a: 30'd1, b: 30'd0, c: 30'd1, d: 30'd0};
      CH_QUERY: m = '{a: 30'd19, b: 30'd7, c: 30'd6, d: 30'd20};
      default: ;
    endcase
    return m;
  endfunction

  function automatic logic [EW-1:0] dot_mod(logic [EW-1:0] x0, logic [EW-1:0] y0,
                                            logic [EW-1:0] x1, logic [EW-1:0] y1);
    longint unsigned p0, p1;
    p0 = (longint'(x0) * longint'(y0)) % PRIME;
    p1 = (longint'(x1) * longint'(y1)) % PRIME;
    return EW'((p0 + p1) % PRIME);
  endfunction

  function automatic mat_t product_mod(mat_t x, mat_t y);
    mat_t r;
    r.a = dot_mod(x.a, y.a, x.b, y.c);
    r.b = dot_mod(x.a, y.b, x.b, y.d);
    r.c = dot_mod(x.c, y.a, x.d, y.c);
    r.d = dot_mod(x.c, y.b, x.d, y.d);
    return r;
  endfunction

  function automatic logic [EW-1:0] write_leaf(logic [POS_W-1:0] pos, logic [SYM_W-1:0] sym);
    int k;
    if (pos < LEAF_COUNT) begin
      k = LEAF_COUNT + pos;
      tree[k] = leaf_matrix(sym);
      k = k / 2;
      while (k >= 1) begin
        tree[k] = product_mod(tree[2*k], tree[2*k+1]);
        k = k / 2;
      end
    end
    return tree[1].a;
  endfunction

  function automatic logic [SYM_W-1:0] pick_symbol();
    logic [SYM_W-1:0] specials [10] = '{CH_A, CH_E, CH_I, CH_O, CH_U, CH_S, CH_D, CH_H,
                                        CH_QUERY, CH_QUERY};
    if ($urandom_range(0, 99) < 65) return specials[$urandom_range(0, 9)];
    return SYM_W'($urandom_range(0, 255));
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Directed rows; typed values are read straight off the leaf matrices.
  initial begin
    stim[0]  = '{10'd0,    CH_PLAIN, 1, 30'd1};
    stim[1]  = '{10'd1023, CH_A,     1, 30'd0};
    stim[2]  = '{10'd1023, CH_PLAIN, 1, 30'd1};
    stim[3]  = '{10'd0,    CH_QUERY, 1, 30'd19};
    stim[4]  = '{10'd0,    CH_H,     1, 30'd1};
    stim[5]  = '{10'd0,    8'hFF,    1, 30'd1};
    stim[6]  = '{10'd0,    8'h00,    1, 30'd1};
    stim[7]  = '{10'd1,    CH_E,     0, 30'd0};
    stim[8]  = '{10'd2,    CH_I,     0, 30'd0};
    stim[9]  = '{10'd3,    CH_O,     0, 30'd0};
    stim[10] = '{10'd512,  CH_U,     0, 30'd0};
    stim[11] = '{10'd511,  CH_S,     0, 30'd0};
    stim[12] = '{10'd700,  CH_D,     0, 30'd0};
    stim[13] = '{10'd1022, CH_QUERY, 0, 30'd0};
    for (int i = N_DIRECTED; i < N_ITEMS; i++) begin
      stim[i].pos = ($urandom_range(0, 99) < 50) ? POS_W'($urandom_range(0, 15))
                                                  : POS_W'($urandom_range(0, 1023));
      stim[i].sym = pick_symbol();
      stim[i].typed = 0;
      stim[i].value = '0;
    end
  end

  // Sampling at the rising edge: predict on accepted input beats, check output beats.
  always @(posedge clk) begin
    logic [EW-1:0] predicted, wanted;
    in_fire = !rst && in_valid && !in_stall;
    if (in_fire) begin
      predicted = write_leaf(position, symbol);
      exp_counts[fed] = stim[fed].typed ? stim[fed].value : predicted;
      fed++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (checked == fed) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat: count=%0d", count);
      end else begin
        wanted = exp_counts[checked];
        checked++;
        if (count !== wanted) begin
          mismatches++;
          if (mismatches <= 10) $display("count mismatch: expected %0d, got %0d", wanted, count);
        end
      end
    end
  end

  // Driving at the falling edge; a long quiet window has no idling on either side.
  initial begin
    int next;
    bit quiet;
    for (int k = 1; k < 2*LEAF_COUNT; k++) tree[k] = IDENTITY;
    rst = 1'b1; in_valid = 1'b0; out_stall = 1'b0; position = '0; symbol = '0;
    fed = 0; checked = 0; mismatches = 0; next = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    while (fed < N_ITEMS) begin
      quiet = (next >= 400 && next < 700);
      out_stall = !quiet && ($urandom_range(0, 99) < 31);
      if (!(in_valid && !in_fire)) begin
        if (next < N_ITEMS && (quiet || $urandom_range(0, 99) >= 31)) begin
          in_valid = 1'b1;
          position = stim[next].pos;
          symbol = stim[next].sym;
          next++;
        end else begin
          in_valid = 1'b0;
          position = POS_W'($urandom);
          symbol = SYM_W'($urandom);
        end
      end
      @(negedge clk);
    end
    in_valid = 1'b0;
    while (checked != fed) begin
      out_stall = ($urandom_range(0, 99) < 31);
      @(negedge clk);
    end
    out_stall = 1'b0;
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && checked == fed) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire
